// ----- design/kvt_pkg.sv -----
// Package for the key-value table: sizes, opcodes and the store port types.
package kvt_pkg;

  localparam int CAPACITY   = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;

  // Fixed widths of the request and result fields.
  localparam int OP_W    = 2;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int COUNT_W = 5;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef struct packed {
    logic en;
    idx_t addr;
    logic wr_key;
    key_t key;
    val_t val;
  } store_wr_t;

  typedef struct packed {
    key_t key;
    val_t val;
  } store_rd_t;

endpackage

// ----- design/kvt_if.sv -----
// Handshake interfaces for the request and result channels.
interface kvt_req_if;
  logic                       valid;
  logic                       ready;
  logic [kvt_pkg::OP_W-1:0]   opcode;
  logic signed [kvt_pkg::KEY_W-1:0] key;
  logic signed [kvt_pkg::VAL_W-1:0] value;

  modport source (output valid, output opcode, output key, output value, input ready);
  modport sink   (input valid, input opcode, input key, input value, output ready);
endinterface

interface kvt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic signed [kvt_pkg::VAL_W-1:0] old_value;
  logic                          status;
  logic [kvt_pkg::COUNT_W-1:0]   entry_count;
  logic                          is_empty;

  modport source (output valid, output found, output old_value, output status,
                  output entry_count, output is_empty, input ready);
  modport sink   (input valid, input found, input old_value, input status,
                  input entry_count, input is_empty, output ready);
endinterface

// ----- design/kvt_store.sv -----
// Key and value memory: one write port, one registered read port.
module kvt_store (
  input  logic               clk,
  input  kvt_pkg::store_wr_t wr,
  input  kvt_pkg::idx_t      raddr,
  output kvt_pkg::store_rd_t rdata
);

  kvt_pkg::key_t key_mem [kvt_pkg::CAPACITY];
  kvt_pkg::val_t val_mem [kvt_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      val_mem[wr.addr] <= wr.val;
      if (wr.wr_key) begin
        key_mem[wr.addr] <= wr.key;
      end
    end
  end

  always_ff @(posedge clk) begin
    rdata.key <= key_mem[raddr];
    rdata.val <= val_mem[raddr];
  end

endmodule

// ----- design/kvt_seq.sv -----
// Sequencer: walks the slots through one key comparator, then applies the update.
module kvt_seq (
  input  logic               clk,
  input  logic               rst,
  kvt_req_if.sink            req,
  kvt_rsp_if.source          rsp,
  output kvt_pkg::store_wr_t wr,
  output kvt_pkg::idx_t      raddr,
  input  kvt_pkg::store_rd_t rdata
);

  typedef enum logic [1:0] {IDLE, SCAN, APPLY} state_t;

  localparam kvt_pkg::idx_t LAST = kvt_pkg::IDX_W'(kvt_pkg::CAPACITY - 1);

  state_t                    state;
  logic [kvt_pkg::OP_W-1:0]  op_q;
  kvt_pkg::key_t             key_q;
  kvt_pkg::val_t             val_q;
  kvt_pkg::idx_t             rd_idx;
  logic                      issuing;
  kvt_pkg::idx_t             cmp_idx;
  logic                      cmp_vld;
  logic                      hit;
  kvt_pkg::idx_t             hit_idx;
  kvt_pkg::val_t             old_q;
  logic                      free_found;
  kvt_pkg::idx_t             free_idx;
  logic [kvt_pkg::CAPACITY-1:0] valid;
  kvt_pkg::cnt_t             count;
  kvt_pkg::cnt_t             count_next;
  logic [kvt_pkg::CAPACITY-1:0] valid_next;
  logic                      status_next;
  logic                      key_match;
  logic                      commit;

  assign req.ready = (state == IDLE);
  assign raddr     = rd_idx;
  assign key_match = valid[cmp_idx] && (rdata.key == key_q);
  assign commit    = (state == APPLY) && (!rsp.valid || rsp.ready);

  // Update decided from the scan result.
  always_comb begin
    count_next  = count;
    valid_next  = valid;
    status_next = 1'b0;
    wr          = '0;
    wr.key      = key_q;
    wr.val      = val_q;
    wr.addr     = hit ? hit_idx : free_idx;
    case (op_q)
      kvt_pkg::OP_ADD: begin
        if (hit) begin
          wr.en = commit;
        end else if (free_found) begin
          wr.en                = commit;
          wr.wr_key            = 1'b1;
          valid_next[free_idx] = 1'b1;
          count_next           = count + kvt_pkg::CNT_W'(1);
        end else begin
          status_next = 1'b1;
        end
      end
      kvt_pkg::OP_REMOVE: begin
        if (hit) begin
          valid_next[hit_idx] = 1'b0;
          if (count != '0) begin
            count_next = count - kvt_pkg::CNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      valid     <= '0;
      count     <= '0;
      rsp.valid <= 1'b0;
      issuing   <= 1'b0;
      cmp_vld   <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && !commit) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (req.valid) begin
            op_q       <= req.opcode;
            key_q      <= kvt_pkg::KEY_BITS'($unsigned(req.key));
            val_q      <= kvt_pkg::VALUE_BITS'($unsigned(req.value));
            rd_idx     <= '0;
            issuing    <= 1'b1;
            cmp_vld    <= 1'b0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            state      <= SCAN;
          end
        end
        SCAN: begin
          // Issue the next address while comparing the entry read last cycle.
          cmp_idx <= rd_idx;
          if (rd_idx != LAST) begin
            rd_idx <= rd_idx + kvt_pkg::IDX_W'(1);
          end
          if (cmp_vld && (key_match || cmp_idx == LAST)) begin
            issuing <= 1'b0;
            cmp_vld <= 1'b0;
            state   <= APPLY;
          end else begin
            cmp_vld <= issuing;
            if (rd_idx == LAST) begin
              issuing <= 1'b0;
            end
          end
          if (cmp_vld) begin
            if (key_match) begin
              hit     <= 1'b1;
              hit_idx <= cmp_idx;
              old_q   <= rdata.val;
            end else if (!valid[cmp_idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= cmp_idx;
            end
          end
        end
        APPLY: begin
          // Hold until the result register is free.
          if (commit) begin
            valid           <= valid_next;
            count           <= count_next;
            rsp.valid       <= 1'b1;
            rsp.found       <= hit;
            rsp.old_value   <= hit ? kvt_pkg::VAL_W'(old_q) : '0;
            rsp.status      <= status_next;
            rsp.entry_count <= kvt_pkg::COUNT_W'(count_next);
            rsp.is_empty    <= (count_next == '0);
            state           <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- design/key_value_table_top.sv -----
// Top level of the key-value table: sequencer plus key/value memory.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    opcode[1:0], key[31:0], value[31:0]
//   rsp      out  valid/ready    found, old_value[31:0], status, entry_count[4:0], is_empty
//
// From accept to result, a single comparator checks one slot a cycle through
// the memory's registered read port, stopping at the first matching key, then
// the APPLY state applies the update. req.ready is high only while no request
// is in work; a result waits in the output register while the next request is
// taken, and a finished request holds until that register is free. Reset
// clears all valid bits and the count; the key and value memory is not cleared.
module key_value_table_top (
  input  logic      clk,
  input  logic      rst,
  kvt_req_if.sink   req,
  kvt_rsp_if.source rsp
);

  kvt_pkg::store_wr_t wr;
  kvt_pkg::idx_t      raddr;
  kvt_pkg::store_rd_t rdata;

  kvt_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rsp   (rsp),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  kvt_store u_store (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("ready stayed high after a request was accepted");

  a_empty_matches_count: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.is_empty == (rsp.entry_count == '0)))
    else $error("empty flag disagrees with entry count");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status) |->
      (!rsp.found && rsp.entry_count == kvt_pkg::COUNT_W'(kvt_pkg::CAPACITY)))
    else $error("full status with a hit or a table that is not full");

  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.found) |-> (rsp.old_value == '0))
    else $error("old value nonzero for an absent key");

endmodule
